>>> hdl/rfds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfds_pkg
// Shared types and constants of the ring fifo with drop statistics.
// ----------------------------------------------------------------------------
package rfds_pkg;

  localparam int unsigned DEPTH_MAX    = 1024;
  localparam int unsigned DATA_WIDTH   = 64;
  localparam int unsigned ADDR_W       = $clog2(DEPTH_MAX);
  localparam int unsigned LEVEL_W      = 11;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned CAP_LOG2_W   = 4;
  localparam int unsigned PAYLOAD_W    = 64;

  localparam logic [CAP_LOG2_W-1:0] CapLog2Reset = CAP_LOG2_W'(10);
  localparam logic [CAP_LOG2_W-1:0] CapLog2Min   = CAP_LOG2_W'(1);
  localparam logic [CAP_LOG2_W-1:0] CapLog2Max   = CAP_LOG2_W'(ADDR_W);

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    command_e               command;
    logic [PAYLOAD_W-1:0]   event_data;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [PAYLOAD_W-1:0]   out_data;
    logic [LEVEL_W-1:0]     fill_level;
    logic [TOTAL_W-1:0]     dropped_total;
    logic [TOTAL_W-1:0]     accepted_total;
    logic [LEVEL_W-1:0]     peak_fill;
  } rsp_t;

  // slot memory access issued by the control unit
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0]  wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } mem_req_t;

  // result fields known to the control unit, payload comes from the memory
  typedef struct packed {
    logic                   valid;
    logic                   rd_hit;
    status_e                status;
    logic [LEVEL_W-1:0]     fill_level;
    logic [TOTAL_W-1:0]     dropped_total;
    logic [TOTAL_W-1:0]     accepted_total;
    logic [LEVEL_W-1:0]     peak_fill;
  } ctrl_rsp_t;

endpackage

>>> hdl/ring_fifo_with_drop_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_with_drop_statistics_core
// Bounded ring fifo in a slot memory, with drop and fill statistics.
// ----------------------------------------------------------------------------
// A request (command, event_data) is taken on a clock edge with start high and
// busy low. An enqueue writes the payload at the tail, or is dropped and
// counted when the ring holds 2^capacity_log2 entries, with capacity_log2
// saturated to 1..10. A dequeue reads the head, or reports empty.
// Each request gives one result on rsp_o, marked by rsp_strobe_o, in the
// cycle after it was taken: the slot memory read data is registered.
// A new request can be taken on every cycle with busy low, so throughput is
// one request per cycle; the memory has one write and one read port, and a request uses at most one.
// Busy is high only during a cycle in which the capacity register is written.
// A capacity write empties the ring and clears all counters; stored payloads
// stay in memory but are no longer reachable.
// Reset sets capacity_log2 to 10 and clears pointers and counters; the slot
// memory is not cleared. The receiver cannot stall: every result is shown
// for one cycle only.
// ----------------------------------------------------------------------------
module ring_fifo_with_drop_statistics_core import rfds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  rsp_strobe_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CAP_LOG2_W-1:0] cfg_wdata_i
);

  logic                  accept;
  mem_req_t              mem_req;
  ctrl_rsp_t             ctrl_rsp;
  logic [DATA_WIDTH-1:0] rdata;

  assign busy   = cfg_we_i;
  assign accept = start & ~busy;

  rfds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_req_o   (mem_req),
    .rsp_o       (ctrl_rsp)
  );

  rfds_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH_MAX)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    rsp_strobe_o         = ctrl_rsp.valid;
    rsp_o.status         = ctrl_rsp.status;
    rsp_o.out_data       = ctrl_rsp.rd_hit ? PAYLOAD_W'(rdata) : '0;
    rsp_o.fill_level     = ctrl_rsp.fill_level;
    rsp_o.dropped_total  = ctrl_rsp.dropped_total;
    rsp_o.accepted_total = ctrl_rsp.accepted_total;
    rsp_o.peak_fill      = ctrl_rsp.peak_fill;
  end

endmodule

>>> hdl/rfds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfds_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rfds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/rfds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfds_ctrl
// Pointers, fill count and statistics; issues slot memory accesses.
// ----------------------------------------------------------------------------
module rfds_ctrl import rfds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  req_t                  req_i,
  input  logic                  cfg_we_i,
  input  logic [CAP_LOG2_W-1:0] cfg_wdata_i,
  output mem_req_t              mem_req_o,
  output ctrl_rsp_t             rsp_o
);

  logic [CAP_LOG2_W-1:0] cap_log2_q;
  logic [ADDR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [LEVEL_W-1:0]    fill_q, fill_d;
  logic [TOTAL_W-1:0]    drop_q, drop_d;
  logic [TOTAL_W-1:0]    acc_q, acc_d;
  logic [LEVEL_W-1:0]    peak_q, peak_d;
  logic                  valid_q;
  logic                  rd_hit_q, rd_hit_d;
  status_e               status_q, status_d;

  logic [CAP_LOG2_W-1:0] lg_eff;
  logic [LEVEL_W-1:0]    cap;
  logic [ADDR_W-1:0]     ptr_mask;

  // saturate the register into the legal range
  always_comb begin
    lg_eff = cap_log2_q;
    if (cap_log2_q < CapLog2Min) begin
      lg_eff = CapLog2Min;
    end else if (cap_log2_q > CapLog2Max) begin
      lg_eff = CapLog2Max;
    end
    cap      = LEVEL_W'(1) << lg_eff;
    ptr_mask = ADDR_W'(cap - LEVEL_W'(1));
  end

  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    fill_d    = fill_q;
    drop_d    = drop_q;
    acc_d     = acc_q;
    peak_d    = peak_q;
    rd_hit_d  = 1'b0;
    status_d  = ST_OK;
    mem_req_o = '0;
    mem_req_o.waddr = wr_ptr_q;
    mem_req_o.wdata = req_i.event_data[DATA_WIDTH-1:0];
    mem_req_o.raddr = rd_ptr_q;
    if (accept_i) begin
      unique case (req_i.command)
        CMD_ENQUEUE: begin
          if (fill_q >= cap) begin
            status_d = ST_FULL;
            drop_d   = drop_q + TOTAL_W'(1);
          end else begin
            mem_req_o.we = 1'b1;
            wr_ptr_d     = (wr_ptr_q + ADDR_W'(1)) & ptr_mask;
            fill_d       = fill_q + LEVEL_W'(1);
            acc_d        = acc_q + TOTAL_W'(1);
            if (fill_d > peak_q) begin
              peak_d = fill_d;
            end
          end
        end
        CMD_DEQUEUE: begin
          if (fill_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            mem_req_o.re = 1'b1;
            rd_hit_d     = 1'b1;
            rd_ptr_d     = (rd_ptr_q + ADDR_W'(1)) & ptr_mask;
            fill_d       = fill_q - LEVEL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= CapLog2Reset;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      fill_q     <= '0;
      drop_q     <= '0;
      acc_q      <= '0;
      peak_q     <= '0;
      valid_q    <= 1'b0;
      rd_hit_q   <= 1'b0;
      status_q   <= ST_OK;
    end else if (cfg_we_i) begin
      cap_log2_q <= cfg_wdata_i;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      fill_q     <= '0;
      drop_q     <= '0;
      acc_q      <= '0;
      peak_q     <= '0;
      valid_q    <= 1'b0;
      rd_hit_q   <= 1'b0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      acc_q    <= acc_d;
      peak_q   <= peak_d;
      valid_q  <= accept_i;
      rd_hit_q <= rd_hit_d;
      status_q <= status_d;
    end
  end

  // counters hold the post-request values during the result cycle
  always_comb begin
    rsp_o.valid          = valid_q;
    rsp_o.rd_hit         = rd_hit_q;
    rsp_o.status         = status_q;
    rsp_o.fill_level     = fill_q;
    rsp_o.dropped_total  = drop_q;
    rsp_o.accepted_total = acc_q;
    rsp_o.peak_fill      = peak_q;
  end

endmodule

>>> dv/ring_fifo_with_drop_statistics_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_with_drop_statistics_core_tb
// Self-checking bench for the ring fifo with drop statistics. Requests go in
// through the start/busy handshake. A ring model in the bench predicts every
// result, and each strobed result is checked field by field against the
// oldest prediction. Directed tests cover the reset state, the smallest ring,
// a zero capacity, a capacity write that drops held entries, and a
// ring filled to the top and wrapped. After these, random traffic runs over
// several capacity settings.
// ----------------------------------------------------------------------------
module ring_fifo_with_drop_statistics_core_tb;
  import rfds_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASE_ITEMS    = 44;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  req_t                  req_i       = '0;
  logic                  rsp_strobe_o;
  rsp_t                  rsp_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CAP_LOG2_W-1:0] cfg_wdata_i = '0;

  // ring model
  logic [DATA_WIDTH-1:0] slot_model [DEPTH_MAX];
  logic [ADDR_W-1:0]     head_ptr;
  logic [ADDR_W-1:0]     tail_ptr;
  logic [LEVEL_W-1:0]    held_count;
  logic [LEVEL_W-1:0]    peak_count;
  logic [TOTAL_W-1:0]    drop_count;
  logic [TOTAL_W-1:0]    accept_count;
  logic [CAP_LOG2_W-1:0] cap_log2_model;

  rsp_t        expected_rsp_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_gaps   = 1'b1;

  always #5 clk_i = ~clk_i;

  ring_fifo_with_drop_statistics_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .rsp_strobe_o (rsp_strobe_o),
    .rsp_o        (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  function automatic void clear_ring_model();
    head_ptr     = '0;
    tail_ptr     = '0;
    held_count   = '0;
    peak_count   = '0;
    drop_count   = '0;
    accept_count = '0;
  endfunction

  function automatic rsp_t predict_fifo_step(req_t rq);
    int unsigned       lg2;
    int unsigned       cap;
    logic [ADDR_W-1:0] mask;
    rsp_t              r;
    // out-of-range register values saturate to the legal capacities
    lg2 = cap_log2_model;
    if (lg2 < CapLog2Min) lg2 = CapLog2Min;
    if (lg2 > CapLog2Max) lg2 = CapLog2Max;
    cap  = 1 << lg2;
    mask = ADDR_W'(cap - 1);
    r        = '0;
    r.status = ST_OK;
    if (rq.command == CMD_ENQUEUE) begin
      if (held_count >= cap) begin
        r.status   = ST_FULL;
        drop_count = drop_count + 1'b1;
      end else begin
        slot_model[tail_ptr & mask] = rq.event_data;
        tail_ptr     = (tail_ptr + 1'b1) & mask;
        held_count   = held_count + 1'b1;
        accept_count = accept_count + 1'b1;
        if (held_count > peak_count) peak_count = held_count;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_data = slot_model[head_ptr & mask];
      head_ptr   = (head_ptr + 1'b1) & mask;
      held_count = held_count - 1'b1;
    end
    r.fill_level     = held_count;
    r.dropped_total  = drop_count;
    r.accepted_total = accept_count;
    r.peak_fill      = peak_count;
    return r;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] random_payload();
    logic [DATA_WIDTH-1:0] d;
    case ($urandom_range(0, 7))
      0: d = '0;
      1: d = '1;
      2: d = DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
      default: d = {$urandom, $urandom};
    endcase
    return d;
  endfunction

  // start stays high across back-to-back requests, dropped only for a gap or a drain
  task automatic send_request(input command_e cmd, input logic [DATA_WIDTH-1:0] data);
    req_t rq;
    rq.command    = cmd;
    rq.event_data = data;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    expected_rsp_q.push_back(predict_fifo_step(rq));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_LOG2_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cap_log2_model  = value;
    clear_ring_model();
  endtask

  task automatic test_reset_state();
    send_request(CMD_DEQUEUE, '1);
    send_request(CMD_ENQUEUE, '0);
    send_request(CMD_ENQUEUE, '1);
    send_request(CMD_DEQUEUE, '0);
    send_request(CMD_DEQUEUE, random_payload());
    send_request(CMD_DEQUEUE, random_payload());
  endtask

  task automatic test_smallest_ring();
    write_capacity(CapLog2Min);
    send_request(CMD_ENQUEUE, 64'h0123_4567_89ab_cdef);
    send_request(CMD_ENQUEUE, 64'hfedc_ba98_7654_3210);
    send_request(CMD_ENQUEUE, '1);
    send_request(CMD_DEQUEUE, '0);
    send_request(CMD_ENQUEUE, 64'h8000_0000_0000_0001);
    send_request(CMD_DEQUEUE, '0);
    send_request(CMD_DEQUEUE, '0);
    send_request(CMD_DEQUEUE, '0);
  endtask

  // zero behaves as a capacity of two
  task automatic test_zero_capacity();
    write_capacity('0);
    send_request(CMD_ENQUEUE, random_payload());
    send_request(CMD_ENQUEUE, random_payload());
    send_request(CMD_ENQUEUE, random_payload());
  endtask

  task automatic test_clear_while_held();
    write_capacity(CAP_LOG2_W'(3));
    send_request(CMD_ENQUEUE, random_payload());
    send_request(CMD_ENQUEUE, random_payload());
    write_capacity(CAP_LOG2_W'(2));
    send_request(CMD_DEQUEUE, '0);
    send_request(CMD_ENQUEUE, random_payload());
    send_request(CMD_DEQUEUE, '0);
  endtask

  // 64-entry ring filled to the top and wrapped
  task automatic test_deepest_ring();
    write_capacity(CAP_LOG2_W'(6));
    repeat (65) send_request(CMD_ENQUEUE, random_payload());
    repeat (8) send_request(CMD_DEQUEUE, random_payload());
    repeat (9) send_request(CMD_ENQUEUE, random_payload());
    repeat (3) send_request(CMD_DEQUEUE, random_payload());
  endtask

  task automatic test_random_traffic();
    logic [CAP_LOG2_W-1:0] cap_plan [10];
    int unsigned           enq_weight;
    cap_plan = '{4'd1, 4'd2, 4'd0, 4'd3, 4'd4, 4'd5, 4'd15, 4'd2, 4'd1, 4'd10};
    cap_plan[7] = CAP_LOG2_W'($urandom_range(0, 15));
    for (int p = 0; p < 10; p++) begin
      if (p >= 7) idle_gaps = 1'b0;
      write_capacity(cap_plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // alternate fill-heavy and drain-heavy stretches
        enq_weight = ((i / 12) % 2 == 0) ? 80 : 25;
        if ($urandom_range(1, 100) <= enq_weight)
          send_request(CMD_ENQUEUE, random_payload());
        else
          send_request(CMD_DEQUEUE, random_payload());
      end
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_strobe_o) begin
      if (expected_rsp_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: status %0d data %h", rsp_o.status, rsp_o.out_data);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.status !== want.status || rsp_o.out_data !== want.out_data ||
            rsp_o.fill_level !== want.fill_level ||
            rsp_o.dropped_total !== want.dropped_total ||
            rsp_o.accepted_total !== want.accepted_total ||
            rsp_o.peak_fill !== want.peak_fill) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch exp: st %0d data %h fill %0d drop %0d acc %0d peak %0d",
                     want.status, want.out_data, want.fill_level, want.dropped_total,
                     want.accepted_total, want.peak_fill);
            $display("         got: st %0d data %h fill %0d drop %0d acc %0d peak %0d",
                     rsp_o.status, rsp_o.out_data, rsp_o.fill_level, rsp_o.dropped_total,
                     rsp_o.accepted_total, rsp_o.peak_fill);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cap_log2_model = CapLog2Reset;
    clear_ring_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_smallest_ring();
    test_zero_capacity();
    test_clear_while_held();
    test_deepest_ring();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
